[rtl/core/peak_to_grain_assign_defines.svh]
// assertion macros shared by the peak_to_grain_assign rtl
`ifndef PEAK_TO_GRAIN_ASSIGN_DEFINES_SVH
`define PEAK_TO_GRAIN_ASSIGN_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define PTGA_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("peak_to_grain_assign: implication check failed");

// implication with a fixed delay in cycles
`define PTGA_ASSERT_DELAY(lbl, clk_s, rstn_s, ante, n, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> ##n (cons)) \
		else $error("peak_to_grain_assign: delayed check failed");

`endif

[rtl/core/ptga_pkg.sv]
// shared widths, register indexes, outcome codes and types for peak_to_grain_assign
`default_nettype none

package ptga_pkg;

	// field widths
	localparam int COEF_W  = 21;
	localparam int G_W     = 32;
	localparam int ROW_W   = 63;
	localparam int ERR_W   = 24;
	localparam int LABEL_W = 16;
	localparam int GRAIN_W = 15;
	localparam int OUT_W   = 2;

	// fraction bits of an index and of an error
	localparam int FRAC_W     = 40;
	localparam int ERR_FRAC_W = 22;

	// index sum, rounded sum and square widths
	localparam int SUM_W   = FRAC_W + 2;
	localparam int S_SHIFT = FRAC_W - ERR_FRAC_W;
	localparam int S22_W   = SUM_W - S_SHIFT;
	localparam int SQ_W    = 2 * S22_W;
	localparam int E_W     = SQ_W + 1 - ERR_FRAC_W;

	// configuration port
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ZERO  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_ONE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_TWO   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GRAIN     = 3'd4;

	// result outcome codes
	localparam logic [OUT_W-1:0] OUTCOME_UNCHANGED = 2'd0;
	localparam logic [OUT_W-1:0] OUTCOME_CLAIM     = 2'd1;
	localparam logic [OUT_W-1:0] OUTCOME_RELEASE   = 2'd2;

	// per-peak fields that ride along the pipeline
	typedef struct packed {
		logic [ERR_W-1:0]   perr;
		logic [LABEL_W-1:0] plab;
		logic               eob;
	} side_t;

endpackage

`default_nettype wire

[rtl/core/peak_to_grain_assign.sv]
// peak_to_grain_assign: six-stage pipeline scoring one peak against one grain
//
// One peak is taken on every clock at which start is high; busy is always low,
// since every stage advances each cycle. The result for a peak appears on the
// result ports with done high five cycles after the accepting edge and is taken
// at the sixth edge, for one cycle only: the receiver cannot stall it, so it
// must take each result as it comes. Latency is set by the pipeline: products,
// row sums, distances, rounded distance sum, square, and the final rounding and
// decision each get a register stage. Configuration registers are read directly
// by the stages and should be written only while no peak is in flight.
`default_nettype none

module peak_to_grain_assign (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// configuration write port
	input  wire logic                                  cfg_write,
	input  wire logic [ptga_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [ptga_pkg::ROW_W-1:0]            cfg_data,
	// request side
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic signed [ptga_pkg::G_W-1:0]       g_x,
	input  wire logic signed [ptga_pkg::G_W-1:0]       g_y,
	input  wire logic signed [ptga_pkg::G_W-1:0]       g_z,
	input  wire logic [ptga_pkg::ERR_W-1:0]            prior_error,
	input  wire logic signed [ptga_pkg::LABEL_W-1:0]   prior_label,
	input  wire logic                                  end_of_batch,
	// result side
	output logic                                       done,
	output logic [ptga_pkg::ERR_W-1:0]                 new_error,
	output logic signed [ptga_pkg::LABEL_W-1:0]        new_label,
	output logic [ptga_pkg::OUT_W-1:0]                 outcome,
	output logic                                       end_of_batch_out
);

`include "peak_to_grain_assign_defines.svh"

	localparam int PROD_W = ptga_pkg::COEF_W + ptga_pkg::G_W;

	// configuration registers
	logic [ptga_pkg::ROW_W-1:0]   mat_q [3];
	logic [ptga_pkg::ERR_W-1:0]   tol_q;
	logic [ptga_pkg::GRAIN_W-1:0] grain_q;

	// pipeline valid bits
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// pipeline payload
	ptga_pkg::side_t                  side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [ptga_pkg::FRAC_W-1:0]      prod_s1 [3][3];
	logic [ptga_pkg::FRAC_W-1:0]      h_s2 [3];
	logic [ptga_pkg::FRAC_W-1:0]      dist_s3 [3];
	logic [ptga_pkg::S22_W-1:0]       s22_s4;
	logic [ptga_pkg::SQ_W-1:0]        sq_s5;
	logic [ptga_pkg::ERR_W-1:0]       new_error_s6;
	logic [ptga_pkg::LABEL_W-1:0]     new_label_s6;
	logic [ptga_pkg::OUT_W-1:0]       outcome_s6;
	logic                             eob_s6;

	// combinational nets
	logic signed [ptga_pkg::COEF_W-1:0] coef [3][3];
	logic signed [ptga_pkg::G_W-1:0]    g_vec [3];
	logic signed [PROD_W-1:0]           prod_full [3][3];
	logic [ptga_pkg::FRAC_W-1:0]        h_next [3];
	logic [ptga_pkg::FRAC_W-1:0]        dist_next [3];
	logic [ptga_pkg::SUM_W-1:0]         dist_sum;
	logic [ptga_pkg::SQ_W:0]            sq_round;
	logic [ptga_pkg::E_W-1:0]           e_wide;
	logic [ptga_pkg::ERR_W-1:0]         e_sat;
	logic                               claim;
	logic                               held;

	// result decode for the checks
	logic                               out_claim;
	logic                               out_release;
	logic                               label_sign;

	// pipeline always advances, never busy
	assign busy = 1'b0;

	// configuration writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mat_q[0] <= '0;
			mat_q[1] <= '0;
			mat_q[2] <= '0;
			tol_q    <= '0;
			grain_q  <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				ptga_pkg::REG_ROW_ZERO:  mat_q[0] <= cfg_data;
				ptga_pkg::REG_ROW_ONE:   mat_q[1] <= cfg_data;
				ptga_pkg::REG_ROW_TWO:   mat_q[2] <= cfg_data;
				ptga_pkg::REG_TOLERANCE: tol_q    <= cfg_data[ptga_pkg::ERR_W-1:0];
				ptga_pkg::REG_GRAIN:     grain_q  <= cfg_data[ptga_pkg::GRAIN_W-1:0];
				default: ;
			endcase
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// unpack coefficients and vector
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				coef[r][c] = mat_q[r][ptga_pkg::COEF_W*c +: ptga_pkg::COEF_W];
			end
		end
		g_vec[0] = g_x;
		g_vec[1] = g_y;
		g_vec[2] = g_z;
	end

	// stage 1: nine products, only the fraction bits matter
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_full[r][c] = PROD_W'(coef[r][c]) * PROD_W'(g_vec[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				prod_s1[r][c] <= prod_full[r][c][ptga_pkg::FRAC_W-1:0];
			end
		end
		side_s1 <= '{perr: prior_error, plab: prior_label, eob: end_of_batch};
	end

	// stage 2: row sums modulo one
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			h_next[r] = prod_s1[r][0] + prod_s1[r][1] + prod_s1[r][2];
		end
	end

	always_ff @(posedge clk) begin
		h_s2    <= h_next;
		side_s2 <= side_s1;
	end

	// stage 3: distance to nearest integer, halves go up
	always_comb begin
		for (int r = 0; r < 3; r++) begin
			if (h_s2[r][ptga_pkg::FRAC_W-1]) begin
				dist_next[r] = ~h_s2[r] + ptga_pkg::FRAC_W'(1);
			end else begin
				dist_next[r] = h_s2[r];
			end
		end
	end

	always_ff @(posedge clk) begin
		dist_s3 <= dist_next;
		side_s3 <= side_s2;
	end

	// stage 4: sum distances and round to error fraction bits
	always_comb begin
		dist_sum = ptga_pkg::SUM_W'(dist_s3[0]) + ptga_pkg::SUM_W'(dist_s3[1])
			+ ptga_pkg::SUM_W'(dist_s3[2])
			+ (ptga_pkg::SUM_W'(1) << (ptga_pkg::S_SHIFT - 1));
	end

	always_ff @(posedge clk) begin
		s22_s4  <= dist_sum[ptga_pkg::SUM_W-1:ptga_pkg::S_SHIFT];
		side_s4 <= side_s3;
	end

	// stage 5: square
	always_ff @(posedge clk) begin
		sq_s5   <= ptga_pkg::SQ_W'(s22_s4) * ptga_pkg::SQ_W'(s22_s4);
		side_s5 <= side_s4;
	end

	// stage 6: round, saturate and decide
	always_comb begin
		sq_round = (ptga_pkg::SQ_W + 1)'(sq_s5)
			+ ((ptga_pkg::SQ_W + 1)'(1) << (ptga_pkg::ERR_FRAC_W - 1));
		e_wide = sq_round[ptga_pkg::SQ_W:ptga_pkg::ERR_FRAC_W];
		if (|e_wide[ptga_pkg::E_W-1:ptga_pkg::ERR_W]) begin
			e_sat = '1;
		end else begin
			e_sat = e_wide[ptga_pkg::ERR_W-1:0];
		end
		claim = (e_sat < tol_q) && (e_sat < side_s5.perr);
		held  = !side_s5.plab[ptga_pkg::LABEL_W-1]
			&& (side_s5.plab[ptga_pkg::GRAIN_W-1:0] == grain_q);
	end

	always_ff @(posedge clk) begin
		eob_s6 <= side_s5.eob;
		priority if (claim) begin
			new_error_s6 <= e_sat;
			new_label_s6 <= {1'b0, grain_q};
			outcome_s6   <= ptga_pkg::OUTCOME_CLAIM;
		end else if (held) begin
			new_error_s6 <= side_s5.perr;
			new_label_s6 <= '1;
			outcome_s6   <= ptga_pkg::OUTCOME_RELEASE;
		end else begin
			new_error_s6 <= side_s5.perr;
			new_label_s6 <= side_s5.plab;
			outcome_s6   <= ptga_pkg::OUTCOME_UNCHANGED;
		end
	end

	// result ports
	assign done             = valid_s6;
	assign new_error        = new_error_s6;
	assign new_label        = new_label_s6;
	assign outcome          = outcome_s6;
	assign end_of_batch_out = eob_s6;

	// result decode for the checks
	assign out_claim   = done && (outcome == ptga_pkg::OUTCOME_CLAIM);
	assign out_release = done && (outcome == ptga_pkg::OUTCOME_RELEASE);
	assign label_sign  = new_label[ptga_pkg::LABEL_W-1];

	// checks
	`PTGA_ASSERT_DELAY(a_fixed_latency, clk, arst_n, start, 6, done)
	`PTGA_ASSERT_IMPL(a_claim_label_positive, clk, arst_n, out_claim, !label_sign)
	`PTGA_ASSERT_IMPL(a_release_label_none, clk, arst_n, out_release, &new_label)

endmodule

`default_nettype wire

[tb/tb.sv]
// testbench for peak_to_grain_assign: scores peaks against a bit-exact predictor
`timescale 1ns / 1ps

module tb;

	// one predicted result per request
	typedef struct packed {
		logic [ptga_pkg::ERR_W-1:0]   err;
		logic [ptga_pkg::LABEL_W-1:0] label;
		logic [ptga_pkg::OUT_W-1:0]   outcome;
		logic                         eob;
	} score_t;

	localparam logic signed [ptga_pkg::G_W-1:0]     HALF_G  = 32'sh0800_0000;
	localparam logic signed [ptga_pkg::G_W-1:0]     ONE_G   = 32'sh1000_0000;
	localparam logic signed [ptga_pkg::COEF_W-1:0]  ONE_Q12 = 21'sd4096;
	localparam logic signed [ptga_pkg::COEF_W-1:0]  COEF_MAX = 21'sh0F_FFFF;
	localparam logic signed [ptga_pkg::COEF_W-1:0]  COEF_MIN = 21'sh10_0000;
	localparam logic [ptga_pkg::ERR_W-1:0]          ERR_MAX = 24'hFF_FFFF;
	localparam logic signed [ptga_pkg::LABEL_W-1:0] NO_GRAIN = -16'sd1;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 cfg_write = 1'b0;
	logic [ptga_pkg::CFG_IDX_W-1:0]       cfg_index = '0;
	logic [ptga_pkg::ROW_W-1:0]           cfg_data = '0;
	logic                                 start = 1'b0;
	logic                                 busy;
	logic signed [ptga_pkg::G_W-1:0]      g_x = '0;
	logic signed [ptga_pkg::G_W-1:0]      g_y = '0;
	logic signed [ptga_pkg::G_W-1:0]      g_z = '0;
	logic [ptga_pkg::ERR_W-1:0]           prior_error = '0;
	logic signed [ptga_pkg::LABEL_W-1:0]  prior_label = '0;
	logic                                 end_of_batch = 1'b0;
	logic                                 done;
	logic [ptga_pkg::ERR_W-1:0]           new_error;
	logic signed [ptga_pkg::LABEL_W-1:0]  new_label;
	logic [ptga_pkg::OUT_W-1:0]           outcome;
	logic                                 end_of_batch_out;

	// mirror of the configuration registers
	logic [ptga_pkg::ROW_W-1:0]   row_shadow [3] = '{default: '0};
	logic [ptga_pkg::ERR_W-1:0]   tol_shadow = '0;
	logic [ptga_pkg::GRAIN_W-1:0] grain_shadow = '0;

	score_t pending_scores [$];
	int     mismatch_count = 0;
	int     sender_idle_pct = 0;

	// current lattice: column, scale shift and sign of each matrix row
	int lat_col [3];
	int lat_shift [3];
	bit lat_neg [3];

	peak_to_grain_assign u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.start            (start),
		.busy             (busy),
		.g_x              (g_x),
		.g_y              (g_y),
		.g_z              (g_z),
		.prior_error      (prior_error),
		.prior_label      (prior_label),
		.end_of_batch     (end_of_batch),
		.done             (done),
		.new_error        (new_error),
		.new_label        (new_label),
		.outcome          (outcome),
		.end_of_batch_out (end_of_batch_out)
	);

	always #5 clk = ~clk;

	// distance of one miller index to its nearest integer, 40 fraction bits
	function automatic logic [ptga_pkg::FRAC_W:0] index_offset(
			input logic [ptga_pkg::ROW_W-1:0] row,
			input logic signed [ptga_pkg::G_W-1:0] gx, input logic signed [ptga_pkg::G_W-1:0] gy,
			input logic signed [ptga_pkg::G_W-1:0] gz);
		logic signed [ptga_pkg::COEF_W-1:0] k0, k1, k2;
		longint                             h;
		logic [ptga_pkg::FRAC_W-1:0]        f;
		k0 = row[ptga_pkg::COEF_W-1:0];
		k1 = row[2*ptga_pkg::COEF_W-1:ptga_pkg::COEF_W];
		k2 = row[3*ptga_pkg::COEF_W-1:2*ptga_pkg::COEF_W];
		h = longint'(k0) * longint'(gx) + longint'(k1) * longint'(gy)
			+ longint'(k2) * longint'(gz);
		f = h[ptga_pkg::FRAC_W-1:0];
		if (!f[ptga_pkg::FRAC_W-1])
			return {1'b0, f};
		return (41'd1 << ptga_pkg::FRAC_W) - {1'b0, f};
	endfunction

	// squared index error and claim or release decision for one peak
	function automatic score_t predict_score(input logic signed [ptga_pkg::G_W-1:0] gx,
			input logic signed [ptga_pkg::G_W-1:0] gy,
			input logic signed [ptga_pkg::G_W-1:0] gz,
			input logic [ptga_pkg::ERR_W-1:0] perr, input logic [ptga_pkg::LABEL_W-1:0] plab,
			input logic eob);
		logic [63:0] s, s22, sq, e;
		score_t      res;
		s = 64'(index_offset(row_shadow[0], gx, gy, gz))
			+ 64'(index_offset(row_shadow[1], gx, gy, gz))
			+ 64'(index_offset(row_shadow[2], gx, gy, gz));
		s22 = (s + (64'd1 << 17)) >> 18;
		sq = s22 * s22;
		e = (sq + (64'd1 << 21)) >> 22;
		if (e > 64'(ERR_MAX))
			e = 64'(ERR_MAX);
		res.eob = eob;
		if (e < 64'(tol_shadow) && e < 64'(perr)) begin
			res.err = e[ptga_pkg::ERR_W-1:0];
			res.label = {1'b0, grain_shadow};
			res.outcome = ptga_pkg::OUTCOME_CLAIM;
		end else if (plab == {1'b0, grain_shadow}) begin
			res.err = perr;
			res.label = NO_GRAIN;
			res.outcome = ptga_pkg::OUTCOME_RELEASE;
		end else begin
			res.err = perr;
			res.label = plab;
			res.outcome = ptga_pkg::OUTCOME_UNCHANGED;
		end
		return res;
	endfunction

	task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
		if (got !== want) begin
			mismatch_count++;
			if (mismatch_count <= 40)
				$display("%0d ns: %s expected %0h actual %0h", $time, what, want, got);
		end
	endtask

	// register mirror, result checking and request capture, all on pre-edge values
	always @(posedge clk) begin
		score_t want;
		if (cfg_write) begin
			case (cfg_index)
				ptga_pkg::REG_ROW_ZERO:  row_shadow[0] = cfg_data;
				ptga_pkg::REG_ROW_ONE:   row_shadow[1] = cfg_data;
				ptga_pkg::REG_ROW_TWO:   row_shadow[2] = cfg_data;
				ptga_pkg::REG_TOLERANCE: tol_shadow = cfg_data[ptga_pkg::ERR_W-1:0];
				ptga_pkg::REG_GRAIN:     grain_shadow = cfg_data[ptga_pkg::GRAIN_W-1:0];
				default: ;
			endcase
		end
		if (done) begin
			if (pending_scores.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 40)
					$display("%0d ns: stray result: expected none actual %h %h %h %b",
						$time, new_error, new_label, outcome, end_of_batch_out);
			end else begin
				want = pending_scores.pop_front();
				check_field("new_error", 32'(want.err), 32'(new_error));
				check_field("new_label", 32'(want.label), 32'($unsigned(new_label)));
				check_field("outcome", 32'(want.outcome), 32'(outcome));
				check_field("end_of_batch_out", 32'(want.eob), 32'(end_of_batch_out));
			end
		end
		if (start && !busy)
			pending_scores.push_back(predict_score(g_x, g_y, g_z, prior_error, prior_label,
				end_of_batch));
	end

	// one request, with random idle cycles ahead of it
	task automatic send_peak(input logic signed [ptga_pkg::G_W-1:0] gx,
			input logic signed [ptga_pkg::G_W-1:0] gy,
			input logic signed [ptga_pkg::G_W-1:0] gz, input logic [ptga_pkg::ERR_W-1:0] perr,
			input logic signed [ptga_pkg::LABEL_W-1:0] plab, input logic eob);
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
		end
		start <= 1'b1;
		g_x <= gx;
		g_y <= gy;
		g_z <= gz;
		prior_error <= perr;
		prior_label <= plab;
		end_of_batch <= eob;
		do @(posedge clk); while (busy);
	endtask

	task automatic write_reg(input logic [ptga_pkg::CFG_IDX_W-1:0] idx,
			input logic [ptga_pkg::ROW_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
	endtask

	// full register load; junk optionally fills the unused upper bits
	task automatic load_grain(input logic [ptga_pkg::ROW_W-1:0] r0,
			input logic [ptga_pkg::ROW_W-1:0] r1,
			input logic [ptga_pkg::ROW_W-1:0] r2, input logic [ptga_pkg::ERR_W-1:0] tol,
			input logic [ptga_pkg::GRAIN_W-1:0] grain, input bit junk);
		logic [63:0] pad;
		pad = junk ? {$urandom, $urandom} : 64'd0;
		write_reg(ptga_pkg::REG_ROW_ZERO, r0);
		write_reg(ptga_pkg::REG_ROW_ONE, r1);
		write_reg(ptga_pkg::REG_ROW_TWO, r2);
		write_reg(ptga_pkg::REG_TOLERANCE, {pad[ptga_pkg::ROW_W-1:ptga_pkg::ERR_W], tol});
		write_reg(ptga_pkg::REG_GRAIN, {pad[ptga_pkg::ROW_W-1:ptga_pkg::GRAIN_W], grain});
		cfg_write <= 1'b0;
	endtask

	// wait for the pipeline to empty before touching registers
	task automatic settle();
		start <= 1'b0;
		while (pending_scores.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// signed permutation matrix scaled by a power of two per row
	task automatic load_lattice(input logic [ptga_pkg::ERR_W-1:0] tol,
			input logic [ptga_pkg::GRAIN_W-1:0] grain);
		logic [ptga_pkg::ROW_W-1:0]         rows [3];
		logic signed [ptga_pkg::COEF_W-1:0] coef;
		int                                 free_col [$];
		int                                 pick;
		free_col = '{0, 1, 2};
		for (int r = 0; r < 3; r++) begin
			pick = $urandom_range(free_col.size() - 1);
			lat_col[r] = free_col[pick];
			free_col.delete(pick);
			lat_shift[r] = $urandom_range(2);
			lat_neg[r] = 1'($urandom_range(1));
			coef = ONE_Q12 <<< lat_shift[r];
			if (lat_neg[r])
				coef = -coef;
			rows[r] = '0;
			rows[r][ptga_pkg::COEF_W*lat_col[r] +: ptga_pkg::COEF_W] = coef;
		end
		load_grain(rows[0], rows[1], rows[2], tol, grain, 1'b1);
	endtask

	// mostly near-lattice vectors when lattice_ok is set, the rest fully random
	task automatic random_peak(input bit lattice_ok);
		logic signed [ptga_pkg::G_W-1:0]     g [3];
		logic [ptga_pkg::ERR_W-1:0]          perr;
		logic signed [ptga_pkg::LABEL_W-1:0] plab;
		longint                              near, wobble;
		int                                  n, k;
		if (lattice_ok && $urandom_range(9) < 8) begin
			for (int r = 0; r < 3; r++) begin
				n = int'($urandom_range(14)) - 7;
				k = $urandom_range(22);
				wobble = longint'($urandom_range(1 << k));
				if ($urandom_range(1))
					wobble = -wobble;
				near = longint'(n) * (longint'(1) << (28 - lat_shift[r])) + wobble;
				g[lat_col[r]] = near[ptga_pkg::G_W-1:0];
			end
		end else begin
			for (int c = 0; c < 3; c++)
				g[c] = $urandom;
		end
		case ($urandom_range(3))
			0: perr = ERR_MAX;
			1: perr = ptga_pkg::ERR_W'($urandom_range(1 << 18));
			2: perr = ptga_pkg::ERR_W'($urandom_range(1 << 14));
			default: perr = ptga_pkg::ERR_W'($urandom);
		endcase
		case ($urandom_range(3))
			0: plab = {1'b0, grain_shadow};
			1: plab = NO_GRAIN;
			2: plab = ptga_pkg::LABEL_W'($urandom_range(32767));
			default: plab = {1'b0, grain_shadow} ^ ptga_pkg::LABEL_W'(1 << $urandom_range(14));
		endcase
		send_peak(g[0], g[1], g[2], perr, plab, $urandom_range(7) == 0);
	endtask

	// extreme coefficients, vectors, errors and labels
	task automatic test_field_extremes();
		settle();
		load_grain({COEF_MIN, COEF_MIN, COEF_MIN}, {COEF_MAX, COEF_MAX, COEF_MAX},
			{COEF_MIN, COEF_MAX, 21'sd1}, ERR_MAX, 15'h7FFF, 1'b0);
		send_peak(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, ERR_MAX, NO_GRAIN, 1'b1);
		send_peak(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, ERR_MAX, 16'sh7FFF, 1'b0);
		send_peak('0, '0, '0, ERR_MAX, 16'sd0, 1'b0);
		send_peak('0, '0, '0, '0, 16'sh7FFF, 1'b1);
		send_peak('0, '0, '0, '0, NO_GRAIN, 1'b0);
		send_peak(32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd1, 24'd1, 16'sh7FFE, 1'b0);
		send_peak(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1, 24'hFF_FFFE, 16'sd1, 1'b1);
	endtask

	// indexes at and around one half, and a peak held by grain zero
	task automatic test_half_rounding();
		settle();
		sender_idle_pct = 17;
		load_grain({42'd0, ONE_Q12}, {21'd0, ONE_Q12, 21'd0}, {ONE_Q12, 42'd0}, ERR_MAX,
			15'd0, 1'b0);
		send_peak(HALF_G, '0, '0, ERR_MAX, NO_GRAIN, 1'b0);
		send_peak(HALF_G - 1, '0, '0, ERR_MAX, 16'sd0, 1'b0);
		send_peak(HALF_G + 1, '0, '0, ERR_MAX, 16'sd3, 1'b1);
		send_peak(-HALF_G, HALF_G, -HALF_G, ERR_MAX, NO_GRAIN, 1'b0);
		send_peak(ONE_G, -ONE_G, '0, 24'd1, NO_GRAIN, 1'b0);
		send_peak(ONE_G, '0, '0, '0, 16'sd0, 1'b1);
		sender_idle_pct = 0;
	endtask

	// zero tolerance claims nothing; unused register indexes change nothing
	task automatic test_unknown_index();
		settle();
		load_grain({42'd0, ONE_Q12}, {21'd0, ONE_Q12, 21'd0}, {ONE_Q12, 42'd0}, '0,
			15'd5, 1'b0);
		for (int idx = ptga_pkg::REG_GRAIN + 1; idx < (1 << ptga_pkg::CFG_IDX_W); idx++)
			write_reg(ptga_pkg::CFG_IDX_W'(idx), ptga_pkg::ROW_W'({$urandom, $urandom}));
		cfg_write <= 1'b0;
		send_peak(ONE_G, ONE_G, -ONE_G, ERR_MAX, 16'sd5, 1'b0);
		send_peak(ONE_G, '0, '0, ERR_MAX, NO_GRAIN, 1'b1);
		send_peak('0, '0, '0, ERR_MAX, 16'sd4, 1'b0);
	endtask

	// random peaks over several register settings and idle patterns
	task automatic test_random_traffic();
		int idle_by_phase [4] = '{0, 76, 0, 17};
		for (int seg = 0; seg < 8; seg++) begin
			settle();
			sender_idle_pct = idle_by_phase[seg % 4];
			case (seg)
				0: load_lattice(ptga_pkg::ERR_W'($urandom_range(1 << 18)), 15'h7FFF);
				1: load_lattice(ptga_pkg::ERR_W'($urandom_range(1 << 18)), 15'd0);
				3: load_grain(ptga_pkg::ROW_W'({$urandom, $urandom}),
					ptga_pkg::ROW_W'({$urandom, $urandom}),
					ptga_pkg::ROW_W'({$urandom, $urandom}), ERR_MAX,
					ptga_pkg::GRAIN_W'($urandom_range(32767)), 1'b1);
				5: load_lattice(ERR_MAX, ptga_pkg::GRAIN_W'($urandom_range(32767)));
				default: load_lattice(ptga_pkg::ERR_W'($urandom_range(1 << 18)),
					ptga_pkg::GRAIN_W'($urandom_range(32767)));
			endcase
			repeat (165) random_peak(seg != 3);
		end
	endtask

	// test sequence
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_field_extremes();
		test_half_rounding();
		test_unknown_index();
		test_random_traffic();
		settle();
		if (mismatch_count == 0 && pending_scores.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// hang guard
	initial begin
		#2_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule
